// ----- hw/rtl/srag_pkg.sv -----
// Package for the sector run address generator.
// Holds the stream payload types, the queue entry type and the code constants.
// No dependencies.
package srag_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_LINEAR = 1'b0;
    localparam logic CMD_CHS    = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_GEOM = 2'd1;
    localparam logic [1:0] ST_OVFL = 2'd2;

    localparam logic [1:0] REG_HPC = 2'd0;
    localparam logic [1:0] REG_SPT = 2'd1;
    localparam logic [1:0] REG_TPS = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] linear_start;
        logic [7:0]  start_cylinder;
        logic [7:0]  start_head;
        logic [7:0]  start_sector;
        logic [6:0]  sector_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cylinder;
        logic [7:0] head;
        logic [7:0] sector;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic        cmd;
        logic [15:0] lba;
        logic [7:0]  cyl;
        logic [7:0]  head;
        logic [7:0]  sec;
        logic [6:0]  count;
    } t_job;

    typedef struct packed {
        logic [7:0] hpc;
        logic [7:0] spt;
        logic [7:0] tps;
    } t_geom;

endpackage

// ----- hw/rtl/srag_stream_if.sv -----
// Valid/ready stream interface used by the sector run address generator.
// The payload type is a parameter; no package dependency.
interface srag_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/srag_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Divides a LINEAR_WIDTH-bit value by an 8-bit divisor; uses srag_pkg.
module srag_div
    import srag_pkg::*;
#(
    parameter int LINEAR_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [LINEAR_WIDTH-1:0] i_dividend,
    input  logic [7:0]              i_divisor,
    output logic                    o_done,
    output logic [LINEAR_WIDTH-1:0] o_quo,
    output logic [7:0]              o_rem
);
    localparam int CW = $clog2(LINEAR_WIDTH + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic [LINEAR_WIDTH-1:0] r_quo;
    logic [7:0]              r_rem;

    logic [8:0]              n_trial;
    logic [8:0]              n_diff;
    logic                    n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[LINEAR_WIDTH-1]};
        n_ge    = n_trial >= {1'b0, i_divisor};
        n_diff  = n_trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CW'(LINEAR_WIDTH);
                r_quo  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo  <= {r_quo[LINEAR_WIDTH-2:0], n_ge};
                r_rem  <= n_ge ? n_diff[7:0] : n_trial[7:0];
                r_cnt  <= r_cnt - CW'(1);
                r_done <= r_cnt == CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ----- hw/rtl/srag_front.sv -----
// Front end: accepts run requests, clamps the sector count and drops empty runs.
// Uses srag_pkg and srag_stream_if; feeds the job queue.
module srag_front
    import srag_pkg::*;
#(
    parameter int MAX_RUN = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    srag_stream_if.sink            i_in,
    output logic                   o_push_valid,
    output t_job                   o_push_job,
    input  logic                   i_push_ready
);
    localparam logic [6:0] MaxCnt = 7'(MAX_RUN);

    logic       r_valid;
    t_job       r_job;
    logic [6:0] n_count;
    logic       n_accept;

    assign i_in.ready = !r_valid || i_push_ready;
    assign n_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_count = (i_in.data.sector_count > MaxCnt) ? MaxCnt : i_in.data.sector_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (n_accept) begin
                r_valid <= (n_count != 7'd0);
            end else if (i_push_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (n_accept) begin
            r_job.cmd   <= i_in.data.cmd;
            r_job.lba   <= i_in.data.linear_start;
            r_job.cyl   <= i_in.data.start_cylinder;
            r_job.head  <= i_in.data.start_head;
            r_job.sec   <= i_in.data.start_sector;
            r_job.count <= n_count;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_job   = r_job;
endmodule

// ----- hw/rtl/srag_queue.sv -----
// Short job queue between the front end and the back end.
// Stores t_job entries from srag_pkg in a small register file.
module srag_queue
    import srag_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop_ready
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          n_push;
    logic          n_pop;

    assign o_push_ready = r_cnt != CW'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != CW'(0);
    assign o_pop_job    = r_mem[r_rd];
    assign n_push       = i_push_valid && o_push_ready;
    assign n_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : r_wr + PW'(1);
            end
            if (n_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : r_rd + PW'(1);
            end
            if (n_push && !n_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (n_pop && !n_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (n_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end
endmodule

// ----- hw/rtl/srag_back.sv -----
// Back end: converts each queued job into one address result per sector.
// Uses srag_pkg, srag_stream_if and the shared divider srag_div.
module srag_back
    import srag_pkg::*;
#(
    parameter int LINEAR_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_geom           i_geom,
    input  logic            i_pop_valid,
    input  t_job            i_pop_job,
    output logic            o_pop_ready,
    srag_stream_if.source   o_res
);
    typedef enum logic [1:0] {S_IDLE, S_DIV1, S_DIV2, S_RUN} t_state;

    t_state                  r_state;
    logic                    r_cmd;
    logic                    r_zgeo;
    logic [LINEAR_WIDTH-1:0] r_lba;
    logic [LINEAR_WIDTH-1:0] r_cyl;
    logic [7:0]              r_head;
    logic [7:0]              r_sec;
    logic [6:0]              r_left;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic                    n_pop;
    logic                    n_zgeo;
    logic                    n_slot;
    logic                    n_emit;
    logic                    n_fin;
    logic                    n_last;
    logic                    n_fail;
    logic                    n_ovf;
    t_out_item               n_result;
    logic                    div_start;
    logic [LINEAR_WIDTH-1:0] div_dividend;
    logic [7:0]              div_divisor;
    logic                    div_done;
    logic [LINEAR_WIDTH-1:0] div_quo;
    logic [7:0]              div_rem;

    srag_div #(.LINEAR_WIDTH(LINEAR_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign o_pop_ready = r_state == S_IDLE;
    assign n_pop       = i_pop_valid && o_pop_ready;
    assign n_zgeo      = (i_geom.hpc == 8'd0) || (i_geom.spt == 8'd0);
    assign n_slot      = !r_out_valid || o_res.ready;
    assign n_emit      = (r_state == S_RUN) && n_slot;

    always_comb begin
        div_start = (n_pop && i_pop_job.cmd == CMD_LINEAR && !n_zgeo)
                 || (r_state == S_DIV1 && div_done);
        div_dividend = (r_state == S_IDLE) ? LINEAR_WIDTH'(i_pop_job.lba) : div_quo;
        div_divisor  = (r_state == S_DIV2) ? i_geom.hpc : i_geom.spt;
    end

    always_comb begin
        n_last = r_left == 7'd1;
        n_ovf  = |r_cyl[LINEAR_WIDTH-1:8];
        n_fail = (r_head >= i_geom.hpc) || (r_cyl[7:0] >= i_geom.tps) || (r_sec > i_geom.spt);
        n_result = '0;
        n_fin    = n_last;
        if (r_cmd == CMD_LINEAR) begin
            if (r_zgeo) begin
                n_result.status = ST_GEOM;
                n_result.last   = 1'b1;
                n_fin           = 1'b1;
            end else if (n_ovf) begin
                n_result.status = ST_OVFL;
                n_result.last   = 1'b1;
                n_fin           = 1'b1;
            end else begin
                n_result.cylinder = r_cyl[7:0];
                n_result.head     = r_head;
                n_result.sector   = r_sec + 8'd1;
                n_result.status   = ST_OK;
                n_result.last     = n_last;
            end
        end else begin
            n_result.cylinder = r_cyl[7:0];
            n_result.head     = r_head;
            n_result.sector   = r_sec;
            n_result.status   = n_fail ? ST_GEOM : ST_OK;
            n_result.last     = n_fail || n_last;
            n_fin             = n_fail || n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_pop) begin
                        r_cmd  <= i_pop_job.cmd;
                        r_zgeo <= n_zgeo;
                        r_lba  <= LINEAR_WIDTH'(i_pop_job.lba);
                        r_cyl  <= LINEAR_WIDTH'(i_pop_job.cyl);
                        r_head <= i_pop_job.head;
                        r_sec  <= i_pop_job.sec;
                        r_left <= i_pop_job.count;
                        if (i_pop_job.cmd == CMD_LINEAR && !n_zgeo) begin
                            r_state <= S_DIV1;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_sec   <= div_rem;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_cyl   <= div_quo;
                        r_head  <= div_rem;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (n_slot) begin
                        r_out       <= n_result;
                        r_left      <= r_left - 7'd1;
                        if (n_fin) begin
                            r_state <= S_IDLE;
                        end
                        if (r_cmd == CMD_CHS) begin
                            r_sec <= r_sec + 8'd1;
                        end else if (&r_lba) begin
                            r_lba  <= '0;
                            r_cyl  <= '0;
                            r_head <= '0;
                            r_sec  <= '0;
                        end else begin
                            r_lba <= r_lba + LINEAR_WIDTH'(1);
                            if (r_sec == i_geom.spt - 8'd1) begin
                                r_sec <= '0;
                                if (r_head == i_geom.hpc - 8'd1) begin
                                    r_head <= '0;
                                    r_cyl  <= r_cyl + LINEAR_WIDTH'(1);
                                end else begin
                                    r_head <= r_head + 8'd1;
                                end
                            end else begin
                                r_sec <= r_sec + 8'd1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
endmodule

// ----- hw/rtl/sector_run_address_generator.sv -----
// A run request of up to MAX_RUN sectors produces one cylinder, head and sector
// result per sector, one result per cycle while the output is taken; an error
// result ends the run early. A linear run with nonzero geometry first passes
// through two divisions on the shared one-bit-per-cycle divider before its first
// result; a cylinder-head-sector run goes from pickup straight to emitting,
// with no division. Runs are handled one at a time in the back end while up to
// three further requests wait in the front register and the job queue. Geometry
// registers are written over the APB port; the user must write them only while
// the block is idle, as the block itself does not enforce this.
// Top level; uses srag_pkg, srag_stream_if, srag_front, srag_queue, srag_back.
module sector_run_address_generator
    import srag_pkg::*;
#(
    parameter int MAX_RUN      = 64,
    parameter int LINEAR_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srag_stream_if.sink   i_in,
    srag_stream_if.source o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    logic [7:0] r_hpc;
    logic [7:0] r_spt;
    logic [7:0] r_tps;
    logic       n_wr;
    t_geom      geom;
    logic       push_valid;
    t_job       push_job;
    logic       push_ready;
    logic       pop_valid;
    t_job       pop_job;
    logic       pop_ready;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpc <= 8'd2;
            r_spt <= 8'd18;
            r_tps <= 8'd80;
        end else if (n_wr) begin
            case (paddr[3:2])
                REG_HPC: r_hpc <= pwdata[7:0];
                REG_SPT: r_spt <= pwdata[7:0];
                REG_TPS: r_tps <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HPC: prdata = {24'd0, r_hpc};
            REG_SPT: prdata = {24'd0, r_spt};
            REG_TPS: prdata = {24'd0, r_tps};
            default: prdata = 32'd0;
        endcase
    end

    assign geom.hpc = r_hpc;
    assign geom.spt = r_spt;
    assign geom.tps = r_tps;

    srag_front #(.MAX_RUN(MAX_RUN)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_job   (push_job),
        .i_push_ready (push_ready)
    );

    srag_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop_ready  (pop_ready)
    );

    srag_back #(.LINEAR_WIDTH(LINEAR_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_pop_valid (pop_valid),
        .i_pop_job   (pop_job),
        .o_pop_ready (pop_ready),
        .o_res       (o_res)
    );
endmodule

// ----- hw/rtl/srag_checker.sv -----
// Port-level checks for the sector run address generator.
// Uses srag_pkg; bound to sector_run_address_generator at the end of this file.
module srag_checker
    import srag_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_out_item  i_out_data
);
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result valid dropped before the transaction completed.");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("Result payload changed while stalled.");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_OK |-> i_out_data.last)
        else $error("An error result did not end its run.");

    a_ovfl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == ST_OVFL |->
        i_out_data.cylinder == 8'd0 && i_out_data.head == 8'd0 && i_out_data.sector == 8'd0)
        else $error("A cylinder overflow result carried a nonzero address.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid was high right after reset.");
endmodule

bind sector_run_address_generator srag_checker u_srag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
